FILE: rtl/lept_pkg.sv
`default_nettype none

package lept_pkg;

    // Default sizes of the store.
    localparam int DEF_PATH_DEPTH = 1024;
    localparam int DEF_COORD_BITS = 8;

    // Fixed widths of the command and result words.
    localparam int FIELD_COORD_W = 8;
    localparam int FIELD_IDX_W   = 10;
    localparam int FIELD_LEN_W   = 11;

    // Command codes. Code 3 is unused and only reports the path length.
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_READ   = 2'd2
    } t_lept_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN
    } t_lept_state;

    typedef struct packed {
        logic [1:0]               op;
        logic [FIELD_COORD_W-1:0] point_x;
        logic [FIELD_COORD_W-1:0] point_y;
        logic [FIELD_IDX_W-1:0]   read_index;
    } t_lept_in;

    typedef struct packed {
        logic [FIELD_LEN_W-1:0]   path_length;
        logic                     loop_cut;
        logic                     dropped;
        logic                     entry_valid;
        logic [FIELD_COORD_W-1:0] entry_x;
        logic [FIELD_COORD_W-1:0] entry_y;
    } t_lept_out;

endpackage

`default_nettype wire

FILE: rtl/loop_erased_path_table.sv
`default_nettype none

// Loop-erased path table. A command word is taken when start is high and busy
// is low; every command gives exactly one result word, shown on o_result for a
// single cycle with o_done high, and the receiver must take it then because it
// cannot hold results off. Clear, the unused code, a read at or beyond the path
// length and an append to an empty path answer in the cycle after they are
// taken; a read inside the path answers through ST_READ, after the registered
// read port. For an append to a non-empty path the stored points are compared
// one per cycle in order from the first, a pace set by the single read port of
// the point memory. busy stays high until the result is shown. The point
// memory has no reset and needs no clearing pass after reset; only entries
// below the stored length are ever used, and all of those were written.
module loop_erased_path_table
    import lept_pkg::*;
#(
    parameter int PATH_DEPTH = DEF_PATH_DEPTH,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    input  wire t_lept_in  i_cmd,
    output logic           busy,
    output logic           o_done,
    output t_lept_out      o_result
);

    // Coordinates arrive as 8-bit fields and are kept in their low COORD_BITS
    // bits, so no more than the narrower of the two is ever stored.
    localparam int CW    = (COORD_BITS < FIELD_COORD_W) ? COORD_BITS : FIELD_COORD_W;
    localparam int AW    = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
    localparam int LEN_W = $clog2(PATH_DEPTH + 1);
    localparam int CMP_W = (LEN_W > FIELD_IDX_W) ? LEN_W : FIELD_IDX_W;

    // Point memory: one write port and one registered read port.
    logic [2*CW-1:0] r_mem [PATH_DEPTH];
    logic [2*CW-1:0] r_rdata;
    logic [AW-1:0]   rd_addr;
    logic            mem_we;
    logic [AW-1:0]   wr_addr;
    logic [2*CW-1:0] wr_data;

    t_lept_state     r_state, n_state;
    logic [LEN_W-1:0] r_len, n_len;
    logic [AW-1:0]   r_ptr, n_ptr;
    logic [CW-1:0]   r_x, n_x;
    logic [CW-1:0]   r_y, n_y;
    logic            r_done, n_done;
    t_lept_out       r_res, n_res;

    logic            accept;
    logic            idx_in_range;
    logic [LEN_W-1:0] ptr_plus_one;
    logic            scan_hit;
    logic            scan_last;
    logic            store_full;

    assign accept       = start && (r_state == ST_IDLE);
    assign idx_in_range = CMP_W'(i_cmd.read_index) < CMP_W'(r_len);
    assign ptr_plus_one = LEN_W'(r_ptr) + LEN_W'(1);
    assign scan_hit     = (r_rdata == {r_x, r_y});
    assign scan_last    = (ptr_plus_one == r_len);
    assign store_full   = (r_len == LEN_W'(PATH_DEPTH));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_x   <= n_x;
        r_y   <= n_y;
        r_res <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_ptr   = r_ptr;
        n_x     = r_x;
        n_y     = r_y;
        n_done  = 1'b0;
        n_res   = r_res;
        rd_addr = '0;
        mem_we  = 1'b0;
        wr_addr = r_len[AW-1:0];
        wr_data = {r_x, r_y};

        case (r_state)
            ST_IDLE: begin
                n_x = CW'(i_cmd.point_x);
                n_y = CW'(i_cmd.point_y);
                if (accept) begin
                    n_res.loop_cut    = 1'b0;
                    n_res.dropped     = 1'b0;
                    n_res.entry_valid = 1'b0;
                    n_res.entry_x     = '0;
                    n_res.entry_y     = '0;
                    n_res.path_length = FIELD_LEN_W'(r_len);
                    case (i_cmd.op)
                        OP_CLEAR: begin
                            n_len             = '0;
                            n_res.path_length = '0;
                            n_done            = 1'b1;
                        end
                        OP_APPEND: begin
                            if (r_len == '0) begin
                                // Empty path: the point goes straight in.
                                mem_we            = 1'b1;
                                wr_addr           = '0;
                                wr_data           = {CW'(i_cmd.point_x), CW'(i_cmd.point_y)};
                                n_len             = LEN_W'(1);
                                n_res.path_length = FIELD_LEN_W'(1);
                                n_done            = 1'b1;
                            end else begin
                                rd_addr = '0;
                                n_ptr   = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        OP_READ: begin
                            if (idx_in_range) begin
                                rd_addr = AW'(i_cmd.read_index);
                                n_state = ST_READ;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            ST_READ: begin
                n_res.entry_valid = 1'b1;
                n_res.entry_x     = FIELD_COORD_W'(r_rdata[2*CW-1:CW]);
                n_res.entry_y     = FIELD_COORD_W'(r_rdata[CW-1:0]);
                n_done            = 1'b1;
                n_state           = ST_IDLE;
            end

            ST_SCAN: begin
                // r_rdata holds the entry at r_ptr; the next one is fetched
                // ahead and simply ignored when the scan ends here. That
                // fetch may hit the entry being written this cycle, which is
                // harmless for the same reason.
                rd_addr = r_ptr + AW'(1);
                n_ptr   = r_ptr + AW'(1);
                if (scan_hit) begin
                    n_len             = ptr_plus_one;
                    n_res.loop_cut    = 1'b1;
                    n_res.path_length = FIELD_LEN_W'(ptr_plus_one);
                    n_done            = 1'b1;
                    n_state           = ST_IDLE;
                end else if (scan_last) begin
                    if (store_full) begin
                        n_res.dropped = 1'b1;
                    end else begin
                        mem_we = 1'b1;
                        n_len  = r_len + LEN_W'(1);
                    end
                    n_res.path_length = FIELD_LEN_W'(store_full ? r_len
                                                               : r_len + LEN_W'(1));
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    // The stored length never passes the depth of the memory.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(PATH_DEPTH))
        else $error("stored length beyond store depth");

    // The scan pointer stays inside the stored path.
    a_scan_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (LEN_W'(r_ptr) < r_len))
        else $error("scan pointer outside the path");

    // A clear answers on the next cycle with an empty path.
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd.op == OP_CLEAR)) |=> (o_done && (o_result.path_length == '0)))
        else $error("clear did not answer with an empty path");

    // A result never reports both a cut and a drop.
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_result.loop_cut && o_result.dropped))
        else $error("cut and drop reported together");

endmodule

`default_nettype wire
